// ----- rtl/core/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants and helpers for the parent transform composition unit.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int PosW   = 32;
  localparam int AngW   = 24;
  localparam int CordW  = 34;
  localparam int ZW     = 34;
  localparam int MaxStages = 30;
  localparam int DefStages = 16;
  localparam int Deg360 = 92160;
  localparam int Deg180 = 46080;
  localparam int Deg90  = 23040;
  localparam logic signed [CordW-1:0] InvGain = 34'sd652032874;

  function automatic logic signed [ZW-1:0] atan_deg22(input int idx);
    logic signed [ZW-1:0] t;
    case (idx)
      0: t = 34'sd188743680;  1: t = 34'sd111421900;  2: t = 34'sd58872272;
      3: t = 34'sd29884485;   4: t = 34'sd15000234;   5: t = 34'sd7507429;
      6: t = 34'sd3754631;    7: t = 34'sd1877430;    8: t = 34'sd938729;
      9: t = 34'sd469366;     10: t = 34'sd234683;    11: t = 34'sd117342;
      12: t = 34'sd58671;     13: t = 34'sd29335;     14: t = 34'sd14668;
      15: t = 34'sd7334;      16: t = 34'sd3667;      17: t = 34'sd1833;
      18: t = 34'sd917;       19: t = 34'sd458;       20: t = 34'sd229;
      21: t = 34'sd115;       22: t = 34'sd57;        23: t = 34'sd29;
      24: t = 34'sd14;        25: t = 34'sd7;         26: t = 34'sd4;
      27: t = 34'sd2;         28: t = 34'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [PosW-1:0] sat32(input logic signed [65:0] v);
    logic signed [PosW-1:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[PosW-1:0];
    return r;
  endfunction

  typedef struct packed {
    logic signed [PosW-1:0] sx;
    logic signed [PosW-1:0] sy;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [AngW-1:0] wa;
    logic signed [PosW-1:0] wsx;
    logic signed [PosW-1:0] wsy;
    logic                   neg;
  } cpt_side_t;

endpackage

// ----- rtl/core/cpt_cell.sv -----
// ----------------------------------------------------------------------------
// cpt_cell
// One CORDIC rotation cell; carries the side payload to its neighbor.
// ----------------------------------------------------------------------------
module cpt_cell #(
  parameter int Idx = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           vld_in,
  input  logic signed [cpt_pkg::CordW-1:0] x_in,
  input  logic signed [cpt_pkg::CordW-1:0] y_in,
  input  logic signed [cpt_pkg::ZW-1:0]    z_in,
  input  cpt_pkg::cpt_side_t               side_in,
  output logic                           vld_out,
  output logic signed [cpt_pkg::CordW-1:0] x_out,
  output logic signed [cpt_pkg::CordW-1:0] y_out,
  output logic signed [cpt_pkg::ZW-1:0]    z_out,
  output cpt_pkg::cpt_side_t               side_out
);
  import cpt_pkg::*;

  logic signed [CordW-1:0] dx, dy;
  logic signed [ZW-1:0]    at;

  assign dx = y_in >>> Idx;
  assign dy = x_in >>> Idx;
  assign at = atan_deg22(Idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - at;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + at;
      end
    end
  end
endmodule

// ----- rtl/core/compose_parent_transform_unit.sv -----
// ----------------------------------------------------------------------------
// compose_parent_transform_unit
// Composes a child 2D transform into its parent's frame.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer accepted per cycle unless the result side stalls.
// Path: stage 1, stage 2, CORDIC cells (one per stage, at most 30), stages A-C,
// output register; a stall on the result side freezes the whole pipeline.
module compose_parent_transform_unit #(
  parameter int CORDIC_STAGES = cpt_pkg::DefStages
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] in_child_x,
  input  logic signed [31:0] in_child_y,
  input  logic signed [23:0] in_child_angle,
  input  logic signed [31:0] in_child_scale_x,
  input  logic signed [31:0] in_child_scale_y,
  input  logic signed [31:0] in_parent_x,
  input  logic signed [31:0] in_parent_y,
  input  logic signed [23:0] in_parent_angle,
  input  logic signed [31:0] in_parent_scale_x,
  input  logic signed [31:0] in_parent_scale_y,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y,
  output logic signed [23:0] out_world_angle,
  output logic signed [31:0] out_world_scale_x,
  output logic signed [31:0] out_world_scale_y
);
  import cpt_pkg::*;

  localparam int NSt = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: products, angle modulo (360 deg = 45 * 2^11; reciprocal for /45)
  logic v1_r;
  logic signed [63:0] psx_r, psy_r, pwsx_r, pwsy_r;
  logic signed [31:0] p1x_r, p1y_r;
  logic signed [AngW-1:0] wa1_r;
  logic [13:0] mh_r;
  logic [7:0]  mq_r;
  logic [10:0] ml_r;
  logic signed [24:0] asum;
  logic [24:0] pa_off;
  logic [27:0] mprod;

  assign asum = 25'(in_child_angle) + 25'(in_parent_angle);
  // offset by 92 turns keeps the angle non-negative
  assign pa_off = 25'(in_parent_angle) + 25'd8478720;
  assign mprod = 28'(pa_off[24:11]) * 28'd11651;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      psx_r  <= 64'(in_child_x) * 64'(in_parent_scale_x);
      psy_r  <= 64'(in_child_y) * 64'(in_parent_scale_y);
      pwsx_r <= 64'(in_child_scale_x) * 64'(in_parent_scale_x);
      pwsy_r <= 64'(in_child_scale_y) * 64'(in_parent_scale_y);
      p1x_r <= in_parent_x;
      p1y_r <= in_parent_y;
      mh_r  <= pa_off[24:11];
      mq_r  <= mprod[26:19];
      ml_r  <= pa_off[10:0];
      if (asum > 25'sd8388607) wa1_r <= 24'sh7FFFFF;
      else if (asum < -25'sd8388608) wa1_r <= 24'sh800000;
      else wa1_r <= asum[23:0];
    end
  end

  // stage 2: round/saturate, fold angle
  logic v2_r;
  cpt_side_t side2_r;
  logic signed [ZW-1:0] z2_r;
  logic [5:0] mrem;
  logic signed [18:0] r0, rf;
  logic negf;

  always_comb begin
    mrem = 6'(mh_r - 14'(mq_r) * 14'd45);
    r0 = 19'({mrem, ml_r});
    if (r0 >= 19'sd46080) r0 = r0 - 19'sd92160;
    negf = 1'b0;
    rf = r0;
    if (r0 > 19'sd23040) begin rf = r0 - 19'sd46080; negf = 1'b1; end
    else if (r0 < -19'sd23040) begin rf = r0 + 19'sd46080; negf = 1'b1; end
  end

  function automatic logic signed [31:0] rq16(input logic signed [63:0] p);
    logic signed [65:0] t;
    t = (66'(p) + 66'sd32768) >>> 16;
    return sat32(t);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side2_r.sx  <= rq16(psx_r);
      side2_r.sy  <= rq16(psy_r);
      side2_r.wsx <= rq16(pwsx_r);
      side2_r.wsy <= rq16(pwsy_r);
      side2_r.px  <= p1x_r;
      side2_r.py  <= p1y_r;
      side2_r.wa  <= wa1_r;
      side2_r.neg <= negf;
      z2_r <= ZW'(rf) <<< 14;
    end
  end

  // CORDIC chain
  logic                    cv [NSt+1];
  logic signed [CordW-1:0] cx [NSt+1];
  logic signed [CordW-1:0] cy [NSt+1];
  logic signed [ZW-1:0]    cz [NSt+1];
  cpt_side_t               cs [NSt+1];

  assign cv[0] = v2_r;
  assign cx[0] = InvGain;
  assign cy[0] = '0;
  assign cz[0] = z2_r;
  assign cs[0] = side2_r;

  for (genvar i = 0; i < NSt; i++) begin : g_cell
    cpt_cell #(.Idx(i)) u_cell (
      .clk, .rst_n, .en,
      .vld_in(cv[i]), .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .side_in(cs[i]),
      .vld_out(cv[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1]),
      .side_out(cs[i+1])
    );
  end

  // stage A: sign fix
  logic v3_r;
  cpt_side_t s3_r;
  logic signed [CordW-1:0] c3_r, sn3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= cv[NSt];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_r  <= cs[NSt];
      c3_r  <= cs[NSt].neg ? -cx[NSt] : cx[NSt];
      sn3_r <= cs[NSt].neg ? -cy[NSt] : cy[NSt];
    end
  end

  // stage B: four products
  logic v4_r;
  cpt_side_t s4_r;
  logic signed [65:0] m_xc_r, m_ys_r, m_xs_r, m_yc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s3_r;
      m_xc_r <= 66'(s3_r.sx) * 66'(c3_r);
      m_ys_r <= 66'(s3_r.sy) * 66'(sn3_r);
      m_xs_r <= 66'(s3_r.sx) * 66'(sn3_r);
      m_yc_r <= 66'(s3_r.sy) * 66'(c3_r);
    end
  end

  // stage C: sums, round, offset
  logic v5_r;
  cpt_side_t s5_r;
  logic signed [67:0] xr_r, yr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s4_r;
      xr_r <= ((68'(m_xc_r) - 68'(m_ys_r) + 68'sd536870912) >>> 30) + 68'(s4_r.px);
      yr_r <= ((68'(m_xs_r) + 68'(m_yc_r) + 68'sd536870912) >>> 30) + 68'(s4_r.py);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_world_x       <= sat32(66'(xr_r));
      out_world_y       <= sat32(66'(yr_r));
      out_world_angle   <= s5_r.wa;
      out_world_scale_x <= s5_r.wsx;
      out_world_scale_y <= s5_r.wsy;
    end
  end
endmodule
